@@ sv/two_channel_window_mean_defines.svh @@
// assertion macros for the two-channel window mean block
// expects clk and rst_n in the scope of the module that includes it
`ifndef TWO_CHANNEL_WINDOW_MEAN_DEFINES_SVH
`define TWO_CHANNEL_WINDOW_MEAN_DEFINES_SVH

// same-cycle implication, quiet while in reset
`define TCWM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tcwm check failed");

// next-cycle implication, quiet while in reset
`define TCWM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tcwm check failed");

`endif

@@ sv/tcwm_pkg.sv @@
// shared types and constants for the two-channel window mean block
// no dependencies
`timescale 1ns / 1ps

package tcwm_pkg;

  localparam int RING_DEPTH  = 16;
  localparam int SAMPLE_W    = 16;
  localparam int FILL_W      = 5;
  localparam int IDX_W       = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int SLOT_W      = IDX_W + 1;
  localparam int CNT_W       = $clog2(RING_DEPTH + 1);
  localparam int SUM_W       = SAMPLE_W + $clog2(RING_DEPTH);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_DROP = 1'b1;

  localparam logic ST_OK         = 1'b0;
  localparam logic ST_DROP_EMPTY = 1'b1;

  typedef struct packed {
    logic                action;
    logic [SAMPLE_W-1:0] sample_gas;
    logic [SAMPLE_W-1:0] sample_voc;
  } in_item_t;

  typedef struct packed {
    logic                status;
    logic [SAMPLE_W-1:0] mean_gas;
    logic [SAMPLE_W-1:0] mean_voc;
    logic [FILL_W-1:0]   fill_count;
    logic                mean_valid;
  } out_item_t;

  // one job handed from the ring front end to the divider
  typedef struct packed {
    logic             status;
    logic [CNT_W-1:0] count;
    logic [SUM_W-1:0] gas_sum;
    logic [SUM_W-1:0] voc_sum;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

@@ sv/two_channel_window_mean.sv @@
// top level of the two-channel window mean block
// depends on tcwm_pkg, tcwm_front, tcwm_queue, tcwm_back and the defines header
`timescale 1ns / 1ps
`include "two_channel_window_mean_defines.svh"

// Moving average over the last RING_DEPTH (16) two-channel samples. Each input
// word either pushes a gas/voc sample (a push into a full ring replaces the
// oldest one) or drops the oldest sample, and gives exactly one result word:
// truncated means of both channels, the fill count, mean_valid, and status 1
// when a drop finds the ring empty (means 0 then). The front end takes a new word
// only once the last one's job is pushed and while the two-entry job queue has
// room; the back end divides both running sums by the fill count one quotient
// bit per cycle, holding the final bit while the output register is full. The
// output register lets the next word divide while a result waits.
module two_channel_window_mean (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  tcwm_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output tcwm_pkg::out_item_t out_data
);
  import tcwm_pkg::*;

  logic      job_push;
  job_t      job_data;
  logic      q_pop;
  job_t      q_data;
  q_status_t q_status;

  tcwm_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_status (q_status),
    .job_push (job_push),
    .job_data (job_data)
  );

  tcwm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (job_push),
    .push_data (job_data),
    .pop       (q_pop),
    .pop_data  (q_data),
    .status    (q_status)
  );

  tcwm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_status  (q_status),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  `TCWM_ASSERT_NOW(a_push_room, job_push, !q_status.full)
  `TCWM_ASSERT_NEXT(a_accept_busy, in_valid && in_ready, !in_ready)
  `TCWM_ASSERT_NOW(a_empty_means, out_valid && !out_data.mean_valid, out_data.mean_gas == '0 && out_data.mean_voc == '0)
  `TCWM_ASSERT_NOW(a_drop_err, out_valid && out_data.status == ST_DROP_EMPTY, !out_data.mean_valid && out_data.fill_count == '0)

endmodule

@@ sv/tcwm_front.sv @@
// ring front end: takes words, keeps the sample ring and the running sums
// depends on tcwm_pkg
`timescale 1ns / 1ps

module tcwm_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  tcwm_pkg::in_item_t  in_data,
  input  tcwm_pkg::q_status_t q_status,
  output logic                job_push,
  output tcwm_pkg::job_t      job_data
);
  import tcwm_pkg::*;

  typedef enum logic [1:0] {
    F_IDLE = 2'b01,
    F_UPD  = 2'b10
  } front_state_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] gas;
    logic [SAMPLE_W-1:0] voc;
  } pair_t;

  front_state_t     state_r, state_nxt;
  in_item_t         item_r;
  logic [IDX_W-1:0] oldest_r, oldest_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [SUM_W-1:0] gas_sum_r, gas_sum_nxt;
  logic [SUM_W-1:0] voc_sum_r, voc_sum_nxt;
  pair_t            ring_mem [RING_DEPTH];
  pair_t            rd_r;

  logic             accept;
  logic             wr_en;
  logic [IDX_W-1:0] wr_slot;
  logic [SLOT_W-1:0] slot_sum;
  logic [IDX_W-1:0] tail_slot;
  logic [IDX_W-1:0] oldest_inc;
  logic             is_full;
  logic             is_empty;
  logic             status;

  assign in_ready = (state_r == F_IDLE) && !q_status.full;
  assign accept   = in_valid && in_ready;

  assign is_full  = (count_r == CNT_W'(RING_DEPTH));
  assign is_empty = (count_r == '0);

  // first free slot, oldest plus count with wrap
  assign slot_sum  = SLOT_W'(oldest_r) + SLOT_W'(count_r);
  assign tail_slot = (slot_sum >= SLOT_W'(RING_DEPTH)) ?
                     IDX_W'(slot_sum - SLOT_W'(RING_DEPTH)) : IDX_W'(slot_sum);
  assign oldest_inc = (oldest_r == IDX_W'(RING_DEPTH - 1)) ? '0 : oldest_r + 1'b1;

  always_comb begin
    state_nxt   = state_r;
    oldest_nxt  = oldest_r;
    count_nxt   = count_r;
    gas_sum_nxt = gas_sum_r;
    voc_sum_nxt = voc_sum_r;
    wr_en       = 1'b0;
    wr_slot     = oldest_r;
    status      = ST_OK;
    job_push    = 1'b0;
    case (state_r)
      F_IDLE: begin
        if (accept) begin
          state_nxt = F_UPD;
        end
      end
      F_UPD: begin
        job_push  = 1'b1;
        state_nxt = F_IDLE;
        if (item_r.action == ACT_PUSH) begin
          wr_en = 1'b1;
          if (is_full) begin
            // overwrite the oldest sample
            wr_slot     = oldest_r;
            gas_sum_nxt = gas_sum_r - SUM_W'(rd_r.gas) + SUM_W'(item_r.sample_gas);
            voc_sum_nxt = voc_sum_r - SUM_W'(rd_r.voc) + SUM_W'(item_r.sample_voc);
            oldest_nxt  = oldest_inc;
          end else begin
            wr_slot     = tail_slot;
            count_nxt   = count_r + 1'b1;
            gas_sum_nxt = gas_sum_r + SUM_W'(item_r.sample_gas);
            voc_sum_nxt = voc_sum_r + SUM_W'(item_r.sample_voc);
          end
        end else if (is_empty) begin
          status = ST_DROP_EMPTY;
        end else begin
          gas_sum_nxt = gas_sum_r - SUM_W'(rd_r.gas);
          voc_sum_nxt = voc_sum_r - SUM_W'(rd_r.voc);
          oldest_nxt  = oldest_inc;
          count_nxt   = count_r - 1'b1;
        end
      end
      default: begin
        state_nxt = F_IDLE;
      end
    endcase
    job_data.status  = status;
    job_data.count   = count_nxt;
    job_data.gas_sum = gas_sum_nxt;
    job_data.voc_sum = voc_sum_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= F_IDLE;
      oldest_r  <= '0;
      count_r   <= '0;
      gas_sum_r <= '0;
      voc_sum_r <= '0;
    end else begin
      state_r   <= state_nxt;
      oldest_r  <= oldest_nxt;
      count_r   <= count_nxt;
      gas_sum_r <= gas_sum_nxt;
      voc_sum_r <= voc_sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_data;
    end
  end

  // sample ring, read of the oldest slot lands in time for the update cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_r <= ring_mem[oldest_r];
    end
    if (wr_en) begin
      ring_mem[wr_slot] <= '{gas: item_r.sample_gas, voc: item_r.sample_voc};
    end
  end

endmodule

@@ sv/tcwm_queue.sv @@
// short job queue between the ring front end and the divider
// depends on tcwm_pkg
`timescale 1ns / 1ps

module tcwm_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  tcwm_pkg::job_t      push_data,
  input  logic                pop,
  output tcwm_pkg::job_t      pop_data,
  output tcwm_pkg::q_status_t status
);
  import tcwm_pkg::*;

  job_t              slots_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] fill_r;

  function automatic logic [QPTR_W-1:0] ptr_inc(logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign status.full  = (fill_r == QCNT_W'(QUEUE_DEPTH));
  assign status.empty = (fill_r == '0);
  assign pop_data     = slots_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (push && !pop) begin
        fill_r <= fill_r + 1'b1;
      end else if (pop && !push) begin
        fill_r <= fill_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ sv/tcwm_back.sv @@
// divider back end: one quotient bit per cycle for both channels (the last waits for a free output), output register
// depends on tcwm_pkg
`timescale 1ns / 1ps

module tcwm_back (
  input  logic                clk,
  input  logic                rst_n,
  input  tcwm_pkg::q_status_t q_status,
  input  tcwm_pkg::job_t      q_data,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output tcwm_pkg::out_item_t out_data
);
  import tcwm_pkg::*;

  localparam int STEP_W = $clog2(SUM_W);

  typedef enum logic [1:0] {
    B_IDLE = 2'b01,
    B_DIV  = 2'b10
  } back_state_t;

  typedef struct packed {
    logic [CNT_W-1:0] rem;
    logic [SUM_W-1:0] dvd;
  } div_st_t;

  back_state_t       state_r, state_nxt;
  logic              status_r, status_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  div_st_t           gas_r, gas_nxt;
  div_st_t           voc_r, voc_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r, out_data_nxt;

  div_st_t           gas_step;
  div_st_t           voc_step;
  logic              last_step;
  logic              out_free;

  // restoring step: shift in the next dividend bit, the quotient bit replaces it
  function automatic div_st_t div_step(div_st_t cur, logic [CNT_W-1:0] dsr);
    logic [CNT_W:0] trial;
    div_st_t        res;
    trial   = {cur.rem, cur.dvd[SUM_W-1]};
    res.dvd = {cur.dvd[SUM_W-2:0], 1'b0};
    res.rem = trial[CNT_W-1:0];
    if (trial >= {1'b0, dsr}) begin
      res.rem    = CNT_W'(trial - {1'b0, dsr});
      res.dvd[0] = 1'b1;
    end
    return res;
  endfunction

  assign gas_step  = div_step(gas_r, cnt_r);
  assign voc_step  = div_step(voc_r, cnt_r);
  assign last_step = (step_r == STEP_W'(SUM_W - 1));
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    status_nxt    = status_r;
    cnt_nxt       = cnt_r;
    gas_nxt       = gas_r;
    voc_nxt       = voc_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    q_pop         = 1'b0;
    case (state_r)
      B_IDLE: begin
        if (!q_status.empty) begin
          q_pop      = 1'b1;
          status_nxt = q_data.status;
          cnt_nxt    = q_data.count;
          gas_nxt    = '{rem: '0, dvd: q_data.gas_sum};
          voc_nxt    = '{rem: '0, dvd: q_data.voc_sum};
          step_nxt   = '0;
          state_nxt  = B_DIV;
        end
      end
      B_DIV: begin
        if (!last_step) begin
          gas_nxt  = gas_step;
          voc_nxt  = voc_step;
          step_nxt = step_r + 1'b1;
        end else if (out_free) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.status     = status_r;
          out_data_nxt.fill_count = FILL_W'(cnt_r);
          out_data_nxt.mean_valid = (cnt_r != '0);
          // empty ring reports zero means
          out_data_nxt.mean_gas   = (cnt_r != '0) ? gas_step.dvd[SAMPLE_W-1:0] : '0;
          out_data_nxt.mean_voc   = (cnt_r != '0) ? voc_step.dvd[SAMPLE_W-1:0] : '0;
          state_nxt               = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r   <= status_nxt;
    cnt_r      <= cnt_nxt;
    gas_r      <= gas_nxt;
    voc_r      <= voc_nxt;
    step_r     <= step_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ dv/testbench.sv @@
// self-checking testbench for the two-channel window mean block
// depends on tcwm_pkg and the two_channel_window_mean top level
`timescale 1ns / 1ps

module testbench;
  import tcwm_pkg::*;

  localparam int RANDOM_WORDS = 1450;
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT = 400000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  two_channel_window_mean dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  in_item_t  pending_words[$];
  out_item_t expected_means[$];

  int total_words = 1;
  int words_taken = 0;
  int results_seen = 0;
  int mismatches = 0;
  int empty_drops = 0;
  int overwrites = 0;
  int cycle_count = 0;
  int sender_idle_pct;
  int receiver_stall_pct;

  // shadow of the ring and its running sums
  logic [SAMPLE_W-1:0] gas_hist[RING_DEPTH];
  logic [SAMPLE_W-1:0] voc_hist[RING_DEPTH];
  int                  ring_head = 0;
  int                  ring_fill = 0;
  int unsigned         gas_total = 0;
  int unsigned         voc_total = 0;

  // idling phases follow progress through the stimulus
  always_comb begin
    case (words_taken * 4 / total_words)
      0: begin
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
      end
      1: begin
        sender_idle_pct = 66;
        receiver_stall_pct = 0;
      end
      2: begin
        sender_idle_pct = 0;
        receiver_stall_pct = 66;
      end
      default: begin
        sender_idle_pct = 9;
        receiver_stall_pct = 9;
      end
    endcase
  end

  function automatic out_item_t mean_after_word(in_item_t w);
    out_item_t r;
    int        slot;
    r = '0;
    r.status = ST_OK;
    if (w.action == ACT_PUSH) begin
      if (ring_fill == RING_DEPTH) begin
        slot = ring_head;
        gas_total -= gas_hist[slot];
        voc_total -= voc_hist[slot];
        ring_head = (ring_head + 1) % RING_DEPTH;
        overwrites++;
      end else begin
        slot = (ring_head + ring_fill) % RING_DEPTH;
        ring_fill++;
      end
      gas_hist[slot] = w.sample_gas;
      voc_hist[slot] = w.sample_voc;
      gas_total += w.sample_gas;
      voc_total += w.sample_voc;
    end else if (ring_fill == 0) begin
      r.status = ST_DROP_EMPTY;
      empty_drops++;
    end else begin
      gas_total -= gas_hist[ring_head];
      voc_total -= voc_hist[ring_head];
      ring_head = (ring_head + 1) % RING_DEPTH;
      ring_fill--;
    end
    if (ring_fill != 0) begin
      r.mean_gas = SAMPLE_W'(gas_total / ring_fill);
      r.mean_voc = SAMPLE_W'(voc_total / ring_fill);
    end
    r.fill_count = FILL_W'(ring_fill);
    r.mean_valid = (ring_fill != 0);
    return r;
  endfunction

  function automatic void check_field(string name, int unsigned exp_val, int unsigned act_val);
    if (exp_val !== act_val) begin
      mismatches++;
      $display("%0t: %s expected %0h actual %0h", $time, name, exp_val, act_val);
    end
  endfunction

  function automatic void queue_word(logic action, logic [SAMPLE_W-1:0] gas,
                                     logic [SAMPLE_W-1:0] voc);
    in_item_t w;
    w.action = action;
    w.sample_gas = gas;
    w.sample_voc = voc;
    pending_words.push_back(w);
  endfunction

  // mostly full-range values, with the extremes now and then
  function automatic logic [SAMPLE_W-1:0] sample_value();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // driver: a word stays on the bus until taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_means.push_back(mean_after_word(in_data));
        words_taken <= words_taken + 1;
      end
      if (!in_valid || in_ready) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          in_data <= pending_words.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: back-pressure and comparison against the oldest expectation
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= receiver_stall_pct);
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_means.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result word, expected none, actual %h", $time, out_data);
        end else begin
          want = expected_means.pop_front();
          check_field("status", want.status, out_data.status);
          check_field("mean_gas", want.mean_gas, out_data.mean_gas);
          check_field("mean_voc", want.mean_voc, out_data.mean_voc);
          check_field("fill_count", want.fill_count, out_data.fill_count);
          check_field("mean_valid", want.mean_valid, out_data.mean_valid);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_means.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int push_bias;
    in_item_t w;
    push_bias = 50;

    // drop on an empty ring, sample fields ignored
    queue_word(ACT_DROP, 16'hA5A5, 16'h5A5A);
    queue_word(ACT_PUSH, 16'h0000, 16'h0000);
    queue_word(ACT_PUSH, 16'hFFFF, 16'hFFFF);
    queue_word(ACT_DROP, 16'h1234, 16'h4321);
    queue_word(ACT_DROP, 16'hFFFF, 16'hFFFF);
    queue_word(ACT_DROP, 16'h0000, 16'h0000);
    // fill to the brim with the largest value so both sums peak
    for (int i = 0; i < RING_DEPTH; i++)
      queue_word(ACT_PUSH, 16'hFFFF, 16'hFFFF);
    // overwrite the oldest while full
    queue_word(ACT_PUSH, 16'h0000, 16'hFFFF);
    queue_word(ACT_PUSH, 16'hFFFF, 16'h0000);
    queue_word(ACT_DROP, 16'h0000, 16'h0000);

    // random runs drift between filling, draining and hovering
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(2))
          0: push_bias = 90;
          1: push_bias = 50;
          default: push_bias = 25;
        endcase
      end
      w.action = ($urandom_range(99) < push_bias) ? ACT_PUSH : ACT_DROP;
      w.sample_gas = sample_value();
      w.sample_voc = sample_value();
      pending_words.push_back(w);
    end
    total_words = pending_words.size();

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_words.size() != 0 || in_valid || expected_means.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("%0d words sent through four idling phases, %0d results checked", words_taken,
             results_seen);
    $display("%0d drops on an empty ring, %0d pushes over a full ring", empty_drops,
             overwrites);
    if (mismatches == 0 && expected_means.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+sv
sv/tcwm_pkg.sv
sv/tcwm_front.sv
sv/tcwm_queue.sv
sv/tcwm_back.sv
sv/two_channel_window_mean.sv
dv/testbench.sv
